// File: sv/fcc_pkg.sv
// shared types, constants and codes of the cluster chain engine
package fcc_pkg;

    // table geometry
    localparam int CL_W         = 12;
    localparam int NUM_CLUSTERS = 2880;
    localparam int ADDR_W       = $clog2(NUM_CLUSTERS);

    // entry values
    localparam logic [CL_W-1:0] END_MARK   = 12'hFFF;
    localparam logic [CL_W-1:0] FREE_ENTRY = 12'h000;

    // operation codes
    localparam logic [2:0] OP_FOLLOW    = 3'd0;
    localparam logic [2:0] OP_EXTEND    = 3'd1;
    localparam logic [2:0] OP_TERMINATE = 3'd2;
    localparam logic [2:0] OP_SET       = 3'd3;
    localparam logic [2:0] OP_ALLOCATE  = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // input beat
    typedef struct packed {
        logic [2:0]      func;
        logic [CL_W-1:0] cluster;
        logic [CL_W-1:0] entry_value;
    } t_in_item;

    // output beat
    typedef struct packed {
        logic [CL_W-1:0] cluster_out;
        logic            chain_end;
        logic [1:0]      status;
    } t_out_item;

    // table memory access from the sequencer
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CL_W-1:0]   wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

// File: sv/fcc_ram.sv
// generic single write port, single read port ram with registered read
module fcc_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 2880,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/fcc_ctrl.sv
// sequencer: table clearing, entry access and the free entry scan
module fcc_ctrl import fcc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  t_in_item        i_item,
    input  logic [CL_W-1:0] i_alloc_start,
    input  logic [CL_W-1:0] i_rdata,
    input  logic            i_res_take,
    output logic            o_idle,
    output logic            o_res_valid,
    output t_out_item       o_res,
    output t_ram_req        o_ram
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_LINK  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam logic [CL_W-1:0] N_CL   = CL_W'(NUM_CLUSTERS);
    localparam logic [CL_W-1:0] LAST_CL = CL_W'(NUM_CLUSTERS - 1);

    logic [2:0]      r_state, n_state;
    logic [CL_W-1:0] r_addr, n_addr;
    logic            r_chk_valid, n_chk_valid;
    logic [CL_W-1:0] r_chk_addr, n_chk_addr;
    logic [CL_W-1:0] r_found, n_found;
    logic [2:0]      r_func, n_func;
    logic [CL_W-1:0] r_cluster, n_cluster;
    t_out_item       r_res, n_res;
    logic            in_range;
    logic            chk_free;

    assign in_range = i_item.cluster < N_CL;
    assign chk_free = r_chk_valid && (i_rdata == FREE_ENTRY);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_chk_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_chk_valid <= n_chk_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_chk_addr <= n_chk_addr;
        r_found    <= n_found;
        r_func     <= n_func;
        r_cluster  <= n_cluster;
        r_res      <= n_res;
    end

    // next state and table access
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_chk_valid = r_chk_valid;
        n_chk_addr  = r_chk_addr;
        n_found     = r_found;
        n_func      = r_func;
        n_cluster   = r_cluster;
        n_res       = r_res;
        o_ram.we    = 1'b0;
        o_ram.waddr = r_addr[ADDR_W-1:0];
        o_ram.wdata = FREE_ENTRY;
        o_ram.raddr = r_addr[ADDR_W-1:0];

        case (r_state)
            // zero every entry after reset, one per cycle
            S_CLEAR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_addr[ADDR_W-1:0];
                o_ram.wdata = FREE_ENTRY;
                n_addr      = r_addr + 1'b1;
                if (r_addr == LAST_CL) begin
                    n_state = S_IDLE;
                end
            end

            // take one beat and dispatch
            S_IDLE: begin
                if (i_start) begin
                    n_func      = i_item.func;
                    n_cluster   = i_item.cluster;
                    n_res       = '0;
                    n_chk_valid = 1'b0;
                    n_state     = S_DONE;
                    case (i_item.func)
                        OP_FOLLOW: begin
                            if (in_range) begin
                                o_ram.raddr = i_item.cluster[ADDR_W-1:0];
                                n_state     = S_READ;
                            end else begin
                                n_res.status    = ST_RANGE;
                                n_res.chain_end = 1'b1;
                            end
                        end
                        OP_EXTEND: begin
                            if (in_range) begin
                                n_addr  = i_alloc_start;
                                n_state = S_SCAN;
                            end else begin
                                n_res.status = ST_RANGE;
                            end
                        end
                        OP_TERMINATE, OP_SET: begin
                            if (in_range) begin
                                o_ram.we    = 1'b1;
                                o_ram.waddr = i_item.cluster[ADDR_W-1:0];
                                o_ram.wdata = (i_item.func == OP_SET) ?
                                              i_item.entry_value : END_MARK;
                            end else begin
                                n_res.status = ST_RANGE;
                            end
                        end
                        OP_ALLOCATE: begin
                            n_addr  = i_alloc_start;
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // follow: entry arrives from the ram
            S_READ: begin
                n_res.cluster_out = i_rdata;
                n_res.chain_end   = (i_rdata == END_MARK) || (i_rdata >= N_CL);
                n_res.status      = ST_OK;
                n_state           = S_DONE;
            end

            // pipelined scan: read one entry a cycle, test the previous one
            S_SCAN: begin
                if (chk_free) begin
                    o_ram.we          = 1'b1;
                    o_ram.waddr       = r_chk_addr[ADDR_W-1:0];
                    o_ram.wdata       = END_MARK;
                    n_found           = r_chk_addr;
                    n_chk_valid       = 1'b0;
                    n_res.cluster_out = r_chk_addr;
                    n_res.status      = ST_OK;
                    n_state           = (r_func == OP_EXTEND) ? S_LINK : S_DONE;
                end else if (r_addr < N_CL) begin
                    o_ram.raddr = r_addr[ADDR_W-1:0];
                    n_chk_addr  = r_addr;
                    n_chk_valid = 1'b1;
                    n_addr      = r_addr + 1'b1;
                end else if (!r_chk_valid) begin
                    // nothing free: extend still closes the chain
                    if (r_func == OP_EXTEND) begin
                        o_ram.we    = 1'b1;
                        o_ram.waddr = r_cluster[ADDR_W-1:0];
                        o_ram.wdata = END_MARK;
                    end
                    n_res.cluster_out = '0;
                    n_res.status      = ST_FULL;
                    n_state           = S_DONE;
                end else begin
                    n_chk_valid = 1'b0;
                end
            end

            // extend: link the acted-on cluster to the new one
            S_LINK: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_cluster[ADDR_W-1:0];
                o_ram.wdata = r_found;
                n_state     = S_DONE;
            end

            // hold the result until the output register frees up
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

// File: sv/fat_cluster_chain_engine.sv
// top level of the cluster chain engine: ports, register, output stage, table ram
//
//  channel   direction  signals                              beat
//  in        input      i_in_valid / o_in_ready / i_in_item  one operation
//  out       output     o_out_valid / i_out_ready / o_out_item  one result
//  cfg       input      i_cfg_we / i_cfg_wdata               alloc_start write
//
// extend and allocate scan one table entry per cycle through the single ram read
// port, from alloc_start up to the last of the NUM_CLUSTERS entries at most.
// after reset a clearing pass writes zero to all NUM_CLUSTERS entries, one per
// cycle; o_in_ready stays low meanwhile, cfg writes are taken.
// a result waits in the output register; the next beat is taken while it waits.
module fat_cluster_chain_engine import fcc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  t_in_item        i_in_item,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output t_out_item       o_out_item,
    input  logic            i_cfg_we,
    input  logic [CL_W-1:0] i_cfg_wdata
);

    logic [CL_W-1:0] r_alloc_start;
    logic            r_out_valid;
    t_out_item       r_out_item;
    logic            ctrl_idle;
    logic            res_valid;
    t_out_item       res;
    logic            res_take;
    t_ram_req        ram_req;
    logic [CL_W-1:0] ram_rdata;
    logic            in_accept;

    assign in_accept = i_in_valid && ctrl_idle;
    assign res_take  = !r_out_valid || i_out_ready;

    // search start register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc_start <= 12'd3;
        end else if (i_cfg_we) begin
            r_alloc_start <= i_cfg_wdata;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res_valid) begin
            r_out_item <= res;
        end
    end

    fcc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (in_accept),
        .i_item        (i_in_item),
        .i_alloc_start (r_alloc_start),
        .i_rdata       (ram_rdata),
        .i_res_take    (res_take),
        .o_idle        (ctrl_idle),
        .o_res_valid   (res_valid),
        .o_res         (res),
        .o_ram         (ram_req)
    );

    fcc_ram #(
        .WIDTH (CL_W),
        .DEPTH (NUM_CLUSTERS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready  = ctrl_idle;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
